// File: rtl/detection_head_cell_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef DETECTION_HEAD_CELL_DECODER_MACROS_SVH
`define DETECTION_HEAD_CELL_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every rising clock edge outside reset.
`define DHCD_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dhcd assertion failed");

// Check that cond is never true outside reset.
`define DHCD_ASSERT_NEVER(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("dhcd forbidden condition");

`else

`define DHCD_ASSERT(name, clk, rstn, prop)
`define DHCD_ASSERT_NEVER(name, clk, rstn, cond)

`endif

`endif

// File: rtl/dhcd_pkg.sv
`timescale 1ns / 1ps

package dhcd_pkg;

    localparam int BINS        = 16;
    localparam int BIN_AW      = $clog2(BINS);
    localparam int MAX_GRID    = 64;
    localparam int MAX_CLASSES = 16;

    localparam int NUM_W = 33;
    localparam int DEN_W = 21;
    localparam int QUO_W = 17;

    localparam logic [1:0] ACT_FRAME = 2'd0;
    localparam logic [1:0] ACT_STAGE = 2'd1;
    localparam logic [1:0] ACT_DATA  = 2'd2;

    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_CLASSES   = 3'd1;
    localparam logic [2:0] CFG_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_MAX_CAND  = 3'd3;
    localparam logic [2:0] CFG_IMAGE     = 3'd4;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_WMAX  = 12'b0000_0000_0010,
        ST_WSUM  = 12'b0000_0000_0100,
        ST_WDIV  = 12'b0000_0000_1000,
        ST_WDIVW = 12'b0000_0001_0000,
        ST_FIN   = 12'b0000_0010_0000,
        ST_SIG   = 12'b0000_0100_0000,
        ST_SIGW  = 12'b0000_1000_0000,
        ST_EDGE  = 12'b0001_0000_0000,
        ST_EDGEW = 12'b0010_0000_0000,
        ST_CHK   = 12'b0100_0000_0000,
        ST_EMIT  = 12'b1000_0000_0000
    } state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

    // exp(-i), Q0.16
    function automatic logic [16:0] exp_int(input logic [3:0] i);
        case (i)
            4'd0:    return 17'd65536;
            4'd1:    return 17'd24109;
            4'd2:    return 17'd8869;
            4'd3:    return 17'd3263;
            4'd4:    return 17'd1200;
            4'd5:    return 17'd442;
            4'd6:    return 17'd162;
            4'd7:    return 17'd60;
            4'd8:    return 17'd22;
            4'd9:    return 17'd8;
            4'd10:   return 17'd3;
            4'd11:   return 17'd1;
            default: return 17'd0;
        endcase
    endfunction

    // exp(-f/16), Q0.16
    function automatic logic [16:0] exp_frac(input logic [3:0] f);
        case (f)
            4'd0:    return 17'd65536;
            4'd1:    return 17'd61565;
            4'd2:    return 17'd57835;
            4'd3:    return 17'd54331;
            4'd4:    return 17'd51039;
            4'd5:    return 17'd47947;
            4'd6:    return 17'd45042;
            4'd7:    return 17'd42313;
            4'd8:    return 17'd39750;
            4'd9:    return 17'd37341;
            4'd10:   return 17'd35079;
            4'd11:   return 17'd32954;
            4'd12:   return 17'd30957;
            4'd13:   return 17'd29081;
            4'd14:   return 17'd27319;
            default: return 17'd25664;
        endcase
    endfunction

    // exp(-t/16) in Q0.16, zero once the integer part reaches 12
    function automatic logic [16:0] exp_neg(input logic [11:0] t);
        logic [33:0] p;
        p = {17'd0, exp_int(t[7:4])} * {17'd0, exp_frac(t[3:0])};
        if (t[11:4] >= 8'd12) begin
            return 17'd0;
        end
        return p[32:16];
    endfunction

endpackage

// File: rtl/detection_head_cell_decoder.sv
`timescale 1ns / 1ps
`include "detection_head_cell_decoder_macros.svh"

// Detection head cell decoder. Takes a quantized detector head one signed
// byte per item, cell by cell in raster order: class scores first, then the
// box bytes (sixteen bins per side in distribution mode, one value per side
// in direct mode, sides ordered left, top, right, bottom). Actions 0 and 1
// latch the stage settings carried on the item (action 0 also restarts the
// frame's candidate count). A cell that passes the raw threshold, the
// sigmoid threshold, the candidate cap and the empty-box check yields one
// result item on its last byte: class, Q0.16 confidence and a Q1.15 box
// clamped to [0,1]. The block takes one item at a time. The last bin of a
// side starts a walk through the 16-entry bin memory (one read port): a
// pass for the maximum, a pass for the weighted sums, then the divider.
// The end of a passing cell runs the shared divider once for the sigmoid
// and up to four times for edge normalization. The result waits in an
// output register, so input flows on while it is unclaimed, unless another
// result is ready. No clearing pass after reset.
module detection_head_cell_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration writes
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic signed [7:0]  s_data_byte,
    input  logic [6:0]         s_grid_size,
    input  logic [2:0]         s_stride_shift,
    input  logic signed [4:0]  s_score_exponent,
    input  logic signed [4:0]  s_box_exponent,
    input  logic signed [7:0]  s_quantized_threshold,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_class_index,
    output logic [15:0]        m_confidence,
    output logic [15:0]        m_left_edge,
    output logic [15:0]        m_top_edge,
    output logic [15:0]        m_right_edge,
    output logic [15:0]        m_bottom_edge
);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    dhcd_pkg::state_t state_reg, state_next;

    // configuration
    logic        mode_reg;
    logic [4:0]  ccount_reg;
    logic [15:0] sthr_reg;
    logic [10:0] maxc_reg;
    logic [10:0] img_reg;

    // stage settings
    logic [6:0]         grid_reg,  grid_next;
    logic [2:0]         shift_reg, shift_next;
    logic signed [4:0]  sexp_reg,  sexp_next;
    logic signed [4:0]  bexp_reg,  bexp_next;
    logic signed [7:0]  qthr_reg,  qthr_next;

    // cell position and class tracking
    logic [5:0]         col_reg,  col_next;
    logic [5:0]         row_reg,  row_next;
    logic [6:0]         byte_reg, byte_next;
    logic [3:0]         bcls_reg, bcls_next;
    logic signed [7:0]  best_reg, best_next;
    logic [10:0]        cand_reg, cand_next;
    logic signed [19:0] dist_reg [4];
    logic signed [19:0] dist_next [4];

    // bin walk
    logic [1:0]         side_reg, side_next;
    logic               last_reg, last_next;
    logic [4:0]         cnt_reg,  cnt_next;
    logic               rdv_reg,  rdv_next;
    logic [3:0]         ridx_reg, ridx_next;
    logic signed [7:0]  mx_reg,   mx_next;
    logic               wv_reg,   wv_next;
    logic [3:0]         widx_reg, widx_next;
    logic [16:0]        w_reg,    w_next;
    logic [20:0]        sw_reg,   sw_next;
    logic [24:0]        siw_reg,  siw_next;

    // cell finish
    logic [16:0]        e_reg,    e_next;
    logic               xneg_reg, xneg_next;
    logic [15:0]        conf_reg, conf_next;
    logic [1:0]         k_reg,    k_next;
    logic [15:0]        edge_reg [4];
    logic [15:0]        edge_next [4];

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [3:0]         o_cls_reg,   o_cls_next;
    logic [15:0]        o_conf_reg,  o_conf_next;
    logic [15:0]        o_l_reg,     o_l_next;
    logic [15:0]        o_t_reg,     o_t_next;
    logic [15:0]        o_r_reg,     o_r_next;
    logic [15:0]        o_b_reg,     o_b_next;

    // ---------------------------------------------------------------
    // Bin memory and shared divider
    // ---------------------------------------------------------------
    logic                        ram_we;
    logic [dhcd_pkg::BIN_AW-1:0] ram_waddr;
    logic [7:0]                  ram_rdata;
    dhcd_pkg::div_req_t          div_req;
    dhcd_pkg::div_rsp_t          div_rsp;

    dhcd_ram #(
        .WIDTH (8),
        .DEPTH (dhcd_pkg::BINS)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data_byte),
        .raddr (cnt_reg[dhcd_pkg::BIN_AW-1:0]),
        .rdata (ram_rdata)
    );

    dhcd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------------------------------------------------------
    // Byte decode
    // ---------------------------------------------------------------
    logic        acc;
    logic [4:0]  nc;
    logic [6:0]  cell_len;
    logic [6:0]  bpos;
    logic [10:0] img_eff;
    logic        issue;
    logic        out_load;

    assign s_ready  = (state_reg == dhcd_pkg::ST_IDLE);
    assign acc      = s_valid && s_ready;
    assign img_eff  = (img_reg == 11'd0) ? 11'd1 : img_reg;
    assign issue    = ((state_reg == dhcd_pkg::ST_WMAX) || (state_reg == dhcd_pkg::ST_WSUM))
                      && !cnt_reg[4];
    assign out_load = (state_reg == dhcd_pkg::ST_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        if (ccount_reg == 5'd0) begin
            nc = 5'd1;
        end else if (ccount_reg > 5'(dhcd_pkg::MAX_CLASSES)) begin
            nc = 5'(dhcd_pkg::MAX_CLASSES);
        end else begin
            nc = ccount_reg;
        end
        cell_len = {2'b0, nc} + (mode_reg ? 7'd64 : 7'd4);
        bpos     = byte_reg - {2'b0, nc};
    end

    // direct-mode distance: raw * 2^(bexp+8), floored, saturated to 20 bits
    function automatic logic signed [19:0] direct_dist(input logic signed [7:0] v,
                                                       input logic signed [4:0] e);
        logic signed [5:0]  s;
        logic [5:0]         ns;
        logic signed [31:0] p;
        s  = {e[4], e} + 6'sd8;
        ns = 6'(-s);
        if (s >= 6'sd0) begin
            p = 32'(v) <<< s[4:0];
        end else begin
            p = 32'(v) >>> ns[3:0];
        end
        if (p > 32'sd524287) begin
            return 20'sd524287;
        end else if (p < -32'sd524288) begin
            return -20'sd524288;
        end
        return p[19:0];
    endfunction

    // ---------------------------------------------------------------
    // Datapath pieces for the walk and the cell finish
    // ---------------------------------------------------------------
    logic [16:0] wt;          // bin weight
    logic [11:0] xt;          // |logit| clamped
    logic        xn;          // logit negative
    logic signed [28:0] edge_v;
    logic        edge_le0;
    logic        edge_ge;

    always_comb begin
        logic signed [5:0]  s;
        logic [5:0]         ns;
        logic [7:0]         diff;
        logic [26:0]        dp;
        logic signed [27:0] xp;
        logic [6:0]         ctr;
        logic [3:0]         sa;
        logic [28:0]        center;
        logic signed [28:0] dsh;

        // weight of one bin: exp(-(max - raw) * 2^(bexp+4) / 16)
        s    = {bexp_reg[4], bexp_reg} + 6'sd4;
        ns   = 6'(-s);
        diff = 8'(mx_reg - $signed(ram_rdata));
        if (s >= 6'sd0) begin
            dp = {19'd0, diff} << s[4:0];
        end else begin
            dp = {19'd0, diff} >> ns[3:0];
        end
        wt = dhcd_pkg::exp_neg((dp > 27'd4095) ? 12'd4095 : dp[11:0]);

        // logit of the best score in Q.4, clamped to +-4095
        s  = {sexp_reg[4], sexp_reg} + 6'sd4;
        ns = 6'(-s);
        if (s >= 6'sd0) begin
            xp = 28'(best_reg) <<< s[4:0];
        end else begin
            xp = 28'(best_reg) >>> ns[3:0];
        end
        xn = xp[27];
        if (xp > 28'sd4095) begin
            xt = 12'd4095;
        end else if (xp < -28'sd4095) begin
            xt = 12'd4095;
        end else if (xn) begin
            xt = 12'(-xp);
        end else begin
            xt = xp[11:0];
        end

        // edge in pixels Q.8: center -+ distance * stride
        ctr      = k_reg[0] ? {row_reg, 1'b1} : {col_reg, 1'b1};
        sa       = 4'd7 + {1'b0, shift_reg};
        center   = {22'd0, ctr} << sa;
        dsh      = 29'(dist_reg[k_reg]) <<< shift_reg;
        edge_v   = k_reg[1] ? ($signed(center) + dsh) : ($signed(center) - dsh);
        edge_le0 = (edge_v <= 29'sd0);
        edge_ge  = (edge_v >= $signed({10'd0, img_eff, 8'd0}));
    end

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    always_comb begin
        logic adv_cell;
        logic [6:0] col_inc;
        logic [6:0] row_inc;

        state_next = state_reg;
        grid_next  = grid_reg;
        shift_next = shift_reg;
        sexp_next  = sexp_reg;
        bexp_next  = bexp_reg;
        qthr_next  = qthr_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        byte_next  = byte_reg;
        bcls_next  = bcls_reg;
        best_next  = best_reg;
        cand_next  = cand_reg;
        for (int i = 0; i < 4; i++) begin
            dist_next[i] = dist_reg[i];
            edge_next[i] = edge_reg[i];
        end
        side_next  = side_reg;
        last_next  = last_reg;
        cnt_next   = issue ? cnt_reg + 5'd1 : cnt_reg;
        rdv_next   = issue;
        ridx_next  = cnt_reg[3:0];
        mx_next    = mx_reg;
        wv_next    = rdv_reg && (state_reg == dhcd_pkg::ST_WSUM);
        widx_next  = ridx_reg;
        w_next     = wt;
        sw_next    = sw_reg;
        siw_next   = siw_reg;
        e_next     = e_reg;
        xneg_next  = xneg_reg;
        conf_next  = conf_reg;
        k_next     = k_reg;
        ram_we     = 1'b0;
        ram_waddr  = bpos[3:0];
        div_req    = '0;
        adv_cell   = 1'b0;

        m_valid_next = m_valid_reg && !m_ready;
        o_cls_next   = o_cls_reg;
        o_conf_next  = o_conf_reg;
        o_l_next     = o_l_reg;
        o_t_next     = o_t_reg;
        o_r_next     = o_r_reg;
        o_b_next     = o_b_reg;

        case (state_reg)
            dhcd_pkg::ST_IDLE: begin
                if (acc) begin
                    case (s_action)
                        dhcd_pkg::ACT_FRAME, dhcd_pkg::ACT_STAGE: begin
                            if (s_action == dhcd_pkg::ACT_FRAME) begin
                                cand_next = '0;
                            end
                            if (s_grid_size == 7'd0) begin
                                grid_next = 7'd1;
                            end else if (s_grid_size > 7'(dhcd_pkg::MAX_GRID)) begin
                                grid_next = 7'(dhcd_pkg::MAX_GRID);
                            end else begin
                                grid_next = s_grid_size;
                            end
                            shift_next = s_stride_shift;
                            sexp_next  = s_score_exponent;
                            bexp_next  = s_box_exponent;
                            qthr_next  = s_quantized_threshold;
                            col_next   = '0;
                            row_next   = '0;
                            byte_next  = '0;
                            bcls_next  = '0;
                            best_next  = -8'sd128;
                        end
                        dhcd_pkg::ACT_DATA: begin
                            if (byte_reg >= cell_len) begin
                                // overrun after a register change: end the cell quietly
                                adv_cell = 1'b1;
                            end else begin
                                byte_next = byte_reg + 7'd1;
                                if (byte_reg < {2'b0, nc}) begin
                                    // first maximum wins
                                    if (byte_reg == 7'd0 || s_data_byte > best_reg) begin
                                        best_next = s_data_byte;
                                        bcls_next = byte_reg[3:0];
                                    end
                                end else if (mode_reg) begin
                                    ram_we    = 1'b1;
                                    side_next = bpos[5:4];
                                    last_next = (bpos == 7'd63);
                                    if (bpos[3:0] == 4'd15) begin
                                        cnt_next   = '0;
                                        state_next = dhcd_pkg::ST_WMAX;
                                    end
                                end else begin
                                    dist_next[bpos[1:0]] = direct_dist(s_data_byte, bexp_reg);
                                    if (bpos == 7'd3) begin
                                        state_next = dhcd_pkg::ST_FIN;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            dhcd_pkg::ST_WMAX: begin
                if (rdv_reg) begin
                    if (ridx_reg == 4'd0 || $signed(ram_rdata) > mx_reg) begin
                        mx_next = $signed(ram_rdata);
                    end
                    if (ridx_reg == 4'd15) begin
                        cnt_next   = '0;
                        sw_next    = '0;
                        siw_next   = '0;
                        state_next = dhcd_pkg::ST_WSUM;
                    end
                end
            end

            dhcd_pkg::ST_WSUM: begin
                if (wv_reg) begin
                    sw_next  = sw_reg + {4'd0, w_reg};
                    siw_next = siw_reg + {4'd0, {4'd0, widx_reg} * {4'd0, w_reg}};
                    if (widx_reg == 4'd15) begin
                        state_next = dhcd_pkg::ST_WDIV;
                    end
                end
            end

            dhcd_pkg::ST_WDIV: begin
                div_req.start = 1'b1;
                div_req.num   = {siw_reg, 8'd0};
                div_req.den   = sw_reg;
                state_next    = dhcd_pkg::ST_WDIVW;
            end

            dhcd_pkg::ST_WDIVW: begin
                if (div_rsp.done) begin
                    dist_next[side_reg] = 20'(div_rsp.quo);
                    state_next = last_reg ? dhcd_pkg::ST_FIN : dhcd_pkg::ST_IDLE;
                end
            end

            dhcd_pkg::ST_FIN: begin
                // drop on cap or raw threshold before any arithmetic
                if (cand_reg >= maxc_reg || best_reg < qthr_reg) begin
                    adv_cell   = 1'b1;
                    state_next = dhcd_pkg::ST_IDLE;
                end else begin
                    e_next     = dhcd_pkg::exp_neg(xt);
                    xneg_next  = xn;
                    state_next = dhcd_pkg::ST_SIG;
                end
            end

            dhcd_pkg::ST_SIG: begin
                div_req.start = 1'b1;
                div_req.num   = xneg_reg ? {e_reg, 16'd0} : {1'b1, 32'd0};
                div_req.den   = 21'd65536 + {4'd0, e_reg};
                state_next    = dhcd_pkg::ST_SIGW;
            end

            dhcd_pkg::ST_SIGW: begin
                if (div_rsp.done) begin
                    conf_next = div_rsp.quo[16] ? 16'hFFFF : div_rsp.quo[15:0];
                    if ((div_rsp.quo[16] ? 16'hFFFF : div_rsp.quo[15:0]) < sthr_reg) begin
                        adv_cell   = 1'b1;
                        state_next = dhcd_pkg::ST_IDLE;
                    end else begin
                        k_next     = '0;
                        state_next = dhcd_pkg::ST_EDGE;
                    end
                end
            end

            dhcd_pkg::ST_EDGE: begin
                if (edge_le0 || edge_ge) begin
                    edge_next[k_reg] = edge_le0 ? 16'd0 : 16'd32768;
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        state_next = dhcd_pkg::ST_CHK;
                    end
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = {7'd0, edge_v[18:0], 7'd0};
                    div_req.den   = {10'd0, img_eff};
                    state_next    = dhcd_pkg::ST_EDGEW;
                end
            end

            dhcd_pkg::ST_EDGEW: begin
                if (div_rsp.done) begin
                    edge_next[k_reg] = div_rsp.quo[15:0];
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? dhcd_pkg::ST_CHK : dhcd_pkg::ST_EDGE;
                end
            end

            dhcd_pkg::ST_CHK: begin
                // empty boxes give no result
                if (edge_reg[2] <= edge_reg[0] || edge_reg[3] <= edge_reg[1]) begin
                    adv_cell   = 1'b1;
                    state_next = dhcd_pkg::ST_IDLE;
                end else begin
                    state_next = dhcd_pkg::ST_EMIT;
                end
            end

            dhcd_pkg::ST_EMIT: begin
                // hold until the result register is free
                if (out_load) begin
                    m_valid_next = 1'b1;
                    o_cls_next   = bcls_reg;
                    o_conf_next  = conf_reg;
                    o_l_next     = edge_reg[0];
                    o_t_next     = edge_reg[1];
                    o_r_next     = edge_reg[2];
                    o_b_next     = edge_reg[3];
                    cand_next    = cand_reg + 11'd1;
                    adv_cell     = 1'b1;
                    state_next   = dhcd_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = dhcd_pkg::ST_IDLE;
            end
        endcase

        // advance to the next cell in raster order, wrapping at the stage end
        col_inc = {1'b0, col_reg} + 7'd1;
        row_inc = {1'b0, row_reg} + 7'd1;
        if (adv_cell) begin
            byte_next = '0;
            bcls_next = '0;
            best_next = -8'sd128;
            if (col_inc >= grid_reg) begin
                col_next = '0;
                row_next = (row_inc >= grid_reg) ? 6'd0 : row_inc[5:0];
            end else begin
                col_next = col_inc[5:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dhcd_pkg::ST_IDLE;
            mode_reg    <= 1'b1;
            ccount_reg  <= 5'd5;
            sthr_reg    <= 16'd32768;
            maxc_reg    <= 11'd256;
            img_reg     <= 11'd224;
            grid_reg    <= '0;
            shift_reg   <= '0;
            sexp_reg    <= '0;
            bexp_reg    <= '0;
            qthr_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            byte_reg    <= '0;
            bcls_reg    <= '0;
            best_reg    <= -8'sd128;
            cand_reg    <= '0;
            for (int i = 0; i < 4; i++) begin
                dist_reg[i] <= '0;
            end
            cnt_reg     <= '0;
            rdv_reg     <= 1'b0;
            wv_reg      <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    dhcd_pkg::CFG_MODE:      mode_reg   <= cfg_wdata[0];
                    dhcd_pkg::CFG_CLASSES:   ccount_reg <= cfg_wdata[4:0];
                    dhcd_pkg::CFG_THRESHOLD: sthr_reg   <= cfg_wdata;
                    dhcd_pkg::CFG_MAX_CAND:  maxc_reg   <= cfg_wdata[10:0];
                    dhcd_pkg::CFG_IMAGE:     img_reg    <= cfg_wdata[10:0];
                    default: ;
                endcase
            end
            state_reg   <= state_next;
            grid_reg    <= grid_next;
            shift_reg   <= shift_next;
            sexp_reg    <= sexp_next;
            bexp_reg    <= bexp_next;
            qthr_reg    <= qthr_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            byte_reg    <= byte_next;
            bcls_reg    <= bcls_next;
            best_reg    <= best_next;
            cand_reg    <= cand_next;
            for (int i = 0; i < 4; i++) begin
                dist_reg[i] <= dist_next[i];
                edge_reg[i] <= edge_next[i];
            end
            side_reg    <= side_next;
            last_reg    <= last_next;
            cnt_reg     <= cnt_next;
            rdv_reg     <= rdv_next;
            ridx_reg    <= ridx_next;
            mx_reg      <= mx_next;
            wv_reg      <= wv_next;
            widx_reg    <= widx_next;
            w_reg       <= w_next;
            sw_reg      <= sw_next;
            siw_reg     <= siw_next;
            e_reg       <= e_next;
            xneg_reg    <= xneg_next;
            conf_reg    <= conf_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
            o_cls_reg   <= o_cls_next;
            o_conf_reg  <= o_conf_next;
            o_l_reg     <= o_l_next;
            o_t_reg     <= o_t_next;
            o_r_reg     <= o_r_next;
            o_b_reg     <= o_b_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_class_index = o_cls_reg;
    assign m_confidence  = o_conf_reg;
    assign m_left_edge   = o_l_reg;
    assign m_top_edge    = o_t_reg;
    assign m_right_edge  = o_r_reg;
    assign m_bottom_edge = o_b_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `DHCD_ASSERT(a_div_start_idle, aclk, aresetn, div_req.start |-> !div_rsp.busy)
    `DHCD_ASSERT(a_sum_has_max_bin, aclk, aresetn, (state_reg == dhcd_pkg::ST_WDIV) |-> (sw_reg >= 21'd65536))
    `DHCD_ASSERT(a_no_overwrite, aclk, aresetn, out_load |-> (!m_valid_reg || m_ready))
    `DHCD_ASSERT_NEVER(a_cell_bound, aclk, aresetn, byte_reg > 7'd80)

endmodule

// File: rtl/dhcd_ram.sv
`timescale 1ns / 1ps

module dhcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/dhcd_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, MSB first.
module dhcd_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  dhcd_pkg::div_req_t  req,
    output dhcd_pkg::div_rsp_t  rsp
);

    localparam int DW = dhcd_pkg::DEN_W + dhcd_pkg::QUO_W - 1;

    logic [dhcd_pkg::NUM_W-1:0] rem_reg,  rem_next;
    logic [DW-1:0]              den_reg,  den_next;
    logic [dhcd_pkg::QUO_W-1:0] quo_reg,  quo_next;
    logic [4:0]                 cnt_reg,  cnt_next;
    logic                       done_reg, done_next;
    logic [DW:0]                diff;

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        diff      = {1'b0, (DW)'(rem_reg)} - {1'b0, den_reg};
        if (req.start) begin
            rem_next = req.num;
            den_next = {req.den, (dhcd_pkg::QUO_W-1)'(0)};
            quo_next = '0;
            cnt_next = 5'(dhcd_pkg::QUO_W);
        end else if (cnt_reg != 5'd0) begin
            if (!diff[DW]) begin
                rem_next = diff[dhcd_pkg::NUM_W-1:0];
                quo_next = {quo_reg[dhcd_pkg::QUO_W-2:0], 1'b1};
            end else begin
                quo_next = {quo_reg[dhcd_pkg::QUO_W-2:0], 1'b0};
            end
            den_next  = den_reg >> 1;
            cnt_next  = cnt_reg - 5'd1;
            done_next = (cnt_reg == 5'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            quo_reg  <= quo_next;
        end
    end

    assign rsp.busy = (cnt_reg != 5'd0);
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule
